/* rtl/cbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and helpers of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int PRG_BANKS_MAX = 16;
    localparam int CHR_BANKS_MAX = 32;

    // remainder unit: dividend width and bits resolved per cycle
    localparam int MOD_W       = 6;
    localparam int MOD_CHUNK_W = 3;
    localparam int MOD_REM_W   = 5;

    // request types
    localparam logic [1:0] REQ_CPU_RD = 2'd0;
    localparam logic [1:0] REQ_CPU_WR = 2'd1;
    localparam logic [1:0] REQ_PPU_RD = 2'd2;
    localparam logic [1:0] REQ_PPU_WR = 2'd3;

    // memory targets
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_CHR_RAM = 3'd4;

    // mapper register selects, address bits 14:12
    localparam logic [2:0] MAP_PRG_SEL = 3'd2;
    localparam logic [2:0] MAP_LO_FD   = 3'd3;
    localparam logic [2:0] MAP_LO_FE   = 3'd4;
    localparam logic [2:0] MAP_HI_FD   = 3'd5;
    localparam logic [2:0] MAP_HI_FE   = 3'd6;
    localparam logic [2:0] MAP_MIRROR  = 3'd7;

    // tile triggers
    localparam logic [11:0] TILE_MASK = 12'hFF8;
    localparam logic [11:0] TILE_FD   = 12'hFD8;
    localparam logic [11:0] TILE_FE   = 12'hFE8;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_CHR_RAM   = 2'd2;

    localparam logic [4:0] PRG_COUNT_RST = 5'd1;
    localparam logic [5:0] CHR_COUNT_RST = 6'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [2:0]  mem_target;
        logic [17:0] mem_addr;
        logic        mem_write;
        logic [7:0]  mem_wdata;
        logic        mirror_horizontal;
    } rsp_t;

    typedef struct packed {
        logic [4:0] prg_bank_count;
        logic [5:0] chr_bank_count;
        logic       chr_is_ram;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic first;
        logic commit;
    } cmd_t;

    function automatic logic [4:0] eff_prg(input logic [4:0] n);
        logic [4:0] r;
        if (n == 5'd0)
            r = 5'd1;
        else if (n > 5'(PRG_BANKS_MAX))
            r = 5'(PRG_BANKS_MAX);
        else
            r = n;
        return r;
    endfunction

    function automatic logic [5:0] eff_chr(input logic [5:0] n);
        logic [5:0] r;
        if (n == 6'd0)
            r = 6'd1;
        else if (n > 6'(CHR_BANKS_MAX))
            r = 6'(CHR_BANKS_MAX);
        else
            r = n;
        return r;
    endfunction

endpackage

/* rtl/cbm_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_mod
// Iterative restoring remainder unit, three dividend bits per cycle.
// ----------------------------------------------------------------------------
module cbm_mod
(
    input  logic                          clk,
    input  logic                          first,
    input  logic [cbm_pkg::MOD_W-1:0]     dividend,
    input  logic [cbm_pkg::MOD_W-1:0]     divisor,
    output logic [cbm_pkg::MOD_REM_W-1:0] remainder
);

    logic [cbm_pkg::MOD_REM_W-1:0]   partial_reg;
    logic [cbm_pkg::MOD_CHUNK_W-1:0] chunk;
    logic [cbm_pkg::MOD_REM_W-1:0]   r_work;
    logic [cbm_pkg::MOD_W-1:0]       r_shift;

    always_comb
    begin
        chunk  = first ? dividend[cbm_pkg::MOD_W-1:cbm_pkg::MOD_CHUNK_W]
                       : dividend[cbm_pkg::MOD_CHUNK_W-1:0];
        r_work = first ? '0 : partial_reg;
        r_shift = '0;
        for (int i = cbm_pkg::MOD_CHUNK_W - 1; i >= 0; i--)
        begin
            r_shift = {r_work, chunk[i]};
            if (r_shift >= divisor)
                r_shift = r_shift - divisor;
            r_work = r_shift[cbm_pkg::MOD_REM_W-1:0];
        end
        remainder = r_work;
    end

    always_ff @(posedge clk)
    begin
        if (first)
            partial_reg <= r_work;
    end

endmodule

/* rtl/cbm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_ctrl
// Access sequencer: takes a transfer, steps the remainder unit, commits.
// ----------------------------------------------------------------------------
module cbm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cbm_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP_HI,
        ST_STEP_LO
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;
    logic   commit;
    logic   accept;

    always_comb
    begin
        out_free  = !rsp_valid_reg || !rsp_stall;
        commit    = (state_reg == ST_STEP_LO) && out_free;
        req_stall = !((state_reg == ST_IDLE) || commit);
        accept    = req_valid && !req_stall;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_STEP_HI;
            end
            ST_STEP_HI:
                state_next = ST_STEP_LO;
            ST_STEP_LO:
            begin
                if (commit)
                    state_next = accept ? ST_STEP_HI : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (commit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;

        cmd.load   = accept;
        cmd.first  = (state_reg == ST_STEP_HI);
        cmd.commit = commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/cbm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_datapath
// Bank registers, tile latches, address decode and result register.
// ----------------------------------------------------------------------------
module cbm_datapath
(
    input  logic          clk,
    input  logic          rst_n,
    input  cbm_pkg::cmd_t cmd,
    input  cbm_pkg::cfg_t cfg,
    input  cbm_pkg::req_t req_data,
    output cbm_pkg::rsp_t rsp_data
);

    cbm_pkg::req_t item_reg;
    cbm_pkg::rsp_t rsp_reg;
    cbm_pkg::rsp_t rsp_next;

    logic [3:0] prg_sel_reg;
    logic [3:0] prg_sel_next;
    logic [4:0] lo_fd_reg;
    logic [4:0] lo_fd_next;
    logic [4:0] lo_fe_reg;
    logic [4:0] lo_fe_next;
    logic [4:0] hi_fd_reg;
    logic [4:0] hi_fd_next;
    logic [4:0] hi_fe_reg;
    logic [4:0] hi_fe_next;
    logic       latch_lo_reg;
    logic       latch_lo_next;
    logic       latch_hi_reg;
    logic       latch_hi_next;
    logic       mirror_reg;
    logic       mirror_next;

    logic [4:0]  pcount;
    logic [5:0]  ccount;
    logic [4:0]  chr_bank;
    logic [3:0]  prg_bank;
    logic [cbm_pkg::MOD_W-1:0]     dividend;
    logic [cbm_pkg::MOD_W-1:0]     divisor;
    logic [cbm_pkg::MOD_REM_W-1:0] remainder;
    logic [15:0] a;
    logic [7:0]  d;
    logic [11:0] tile;
    logic        chr_hit;
    logic        latch_upd;

    cbm_mod u_mod
    (
        .clk       (clk),
        .first     (cmd.first),
        .dividend  (dividend),
        .divisor   (divisor),
        .remainder (remainder)
    );

    always_comb
    begin
        a      = item_reg.addr;
        d      = item_reg.write_data;
        tile   = a[11:0] & cbm_pkg::TILE_MASK;
        pcount = cbm_pkg::eff_prg(cfg.prg_bank_count);
        ccount = cbm_pkg::eff_chr(cfg.chr_bank_count);

        if (a[12])
            chr_bank = latch_hi_reg ? hi_fe_reg : hi_fd_reg;
        else
            chr_bank = latch_lo_reg ? lo_fe_reg : lo_fd_reg;

        prg_bank = (a[15:14] == 2'b10) ? prg_sel_reg : 4'(pcount - 5'd1);

        case (item_reg.req_type)
            cbm_pkg::REQ_CPU_RD:
            begin
                dividend = cbm_pkg::MOD_W'(prg_bank);
                divisor  = cbm_pkg::MOD_W'(pcount);
            end
            cbm_pkg::REQ_CPU_WR:
            begin
                dividend = cbm_pkg::MOD_W'(d[3:0]);
                divisor  = cbm_pkg::MOD_W'(pcount);
            end
            default:
            begin
                dividend = cbm_pkg::MOD_W'(chr_bank);
                divisor  = ccount;
            end
        endcase
    end

    always_comb
    begin
        prg_sel_next  = prg_sel_reg;
        lo_fd_next    = lo_fd_reg;
        lo_fe_next    = lo_fe_reg;
        hi_fd_next    = hi_fd_reg;
        hi_fe_next    = hi_fe_reg;
        latch_lo_next = latch_lo_reg;
        latch_hi_next = latch_hi_reg;
        mirror_next   = mirror_reg;
        chr_hit       = 1'b0;
        latch_upd     = 1'b0;

        rsp_next.mem_target = cbm_pkg::TGT_NONE;
        rsp_next.mem_addr   = '0;
        rsp_next.mem_write  = 1'b0;

        case (item_reg.req_type)
            cbm_pkg::REQ_CPU_RD:
            begin
                if (a[15])
                begin
                    rsp_next.mem_target = cbm_pkg::TGT_PRG_ROM;
                    rsp_next.mem_addr   = {remainder[3:0], a[13:0]};
                end
                else if (a[14:13] == 2'b11)
                begin
                    rsp_next.mem_target = cbm_pkg::TGT_PRG_RAM;
                    rsp_next.mem_addr   = {5'd0, a[12:0]};
                end
            end
            cbm_pkg::REQ_CPU_WR:
            begin
                if (a[15] && (a[14] || a[13]))
                begin
                    unique case (a[14:12])
                        cbm_pkg::MAP_PRG_SEL: prg_sel_next = remainder[3:0];
                        cbm_pkg::MAP_LO_FD:   lo_fd_next   = d[4:0];
                        cbm_pkg::MAP_LO_FE:   lo_fe_next   = d[4:0];
                        cbm_pkg::MAP_HI_FD:   hi_fd_next   = d[4:0];
                        cbm_pkg::MAP_HI_FE:   hi_fe_next   = d[4:0];
                        cbm_pkg::MAP_MIRROR:  mirror_next  = d[0];
                        default:              mirror_next  = mirror_reg;
                    endcase
                end
                else if (a[15:13] == 3'b011)
                begin
                    rsp_next.mem_target = cbm_pkg::TGT_PRG_RAM;
                    rsp_next.mem_addr   = {5'd0, a[12:0]};
                    rsp_next.mem_write  = 1'b1;
                end
            end
            cbm_pkg::REQ_PPU_RD:
            begin
                if (a[15:13] == 3'b000)
                begin
                    chr_hit             = 1'b1;
                    latch_upd           = 1'b1;
                    rsp_next.mem_target = cfg.chr_is_ram ? cbm_pkg::TGT_CHR_RAM
                                                         : cbm_pkg::TGT_CHR_ROM;
                end
            end
            default:
            begin
                if ((a[15:13] == 3'b000) && cfg.chr_is_ram)
                begin
                    chr_hit             = 1'b1;
                    latch_upd           = 1'b1;
                    rsp_next.mem_target = cbm_pkg::TGT_CHR_RAM;
                    rsp_next.mem_write  = 1'b1;
                end
            end
        endcase

        if (chr_hit)
            rsp_next.mem_addr = {1'b0, remainder, a[11:0]};

        if (latch_upd)
        begin
            if (a[12])
            begin
                if (tile == cbm_pkg::TILE_FD)
                    latch_hi_next = 1'b0;
                else if (tile == cbm_pkg::TILE_FE)
                    latch_hi_next = 1'b1;
            end
            else
            begin
                if (tile == cbm_pkg::TILE_FD)
                    latch_lo_next = 1'b0;
                else if (tile == cbm_pkg::TILE_FE)
                    latch_lo_next = 1'b1;
            end
        end

        rsp_next.mem_wdata         = rsp_next.mem_write ? d : 8'd0;
        rsp_next.mirror_horizontal = mirror_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_sel_reg  <= '0;
            lo_fd_reg    <= '0;
            lo_fe_reg    <= '0;
            hi_fd_reg    <= '0;
            hi_fe_reg    <= '0;
            latch_lo_reg <= 1'b1;
            latch_hi_reg <= 1'b1;
            mirror_reg   <= 1'b0;
        end
        else if (cmd.commit)
        begin
            prg_sel_reg  <= prg_sel_next;
            lo_fd_reg    <= lo_fd_next;
            lo_fe_reg    <= lo_fe_next;
            hi_fd_reg    <= hi_fd_next;
            hi_fe_reg    <= hi_fe_next;
            latch_lo_reg <= latch_lo_next;
            latch_hi_reg <= latch_hi_next;
            mirror_reg   <= mirror_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= req_data;
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    assign rsp_data = rsp_reg;

endmodule

/* rtl/cartridge_bank_mapper_tile_latch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_tile_latch
// Bank mapper with tile-triggered pattern latches and an APB register port.
// ----------------------------------------------------------------------------
// Each access steps a remainder unit that reduces the bank number modulo the
// bank count and resolves three bits per cycle. The next access is taken in
// the cycle its predecessor commits, so accesses overlap while the result side
// keeps up. A held result blocks the commit of the following access until the
// transfer completes. Bank registers, tile latches and mirroring update only
// at commit.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_tile_latch
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          req_valid,
    output logic          req_stall,
    input  cbm_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cbm_pkg::rsp_t rsp_data
);

    logic [4:0]    prg_count_reg;
    logic [5:0]    chr_count_reg;
    logic          chr_ram_reg;
    logic          cfg_wr;
    cbm_pkg::cfg_t cfg;
    cbm_pkg::cmd_t cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= cbm_pkg::PRG_COUNT_RST;
            chr_count_reg <= cbm_pkg::CHR_COUNT_RST;
            chr_ram_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                cbm_pkg::CFG_PRG_COUNT: prg_count_reg <= pwdata[4:0];
                cbm_pkg::CFG_CHR_COUNT: chr_count_reg <= pwdata[5:0];
                cbm_pkg::CFG_CHR_RAM:   chr_ram_reg   <= pwdata[0];
                default:                chr_ram_reg   <= chr_ram_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            cbm_pkg::CFG_PRG_COUNT: prdata = {27'd0, prg_count_reg};
            cbm_pkg::CFG_CHR_COUNT: prdata = {26'd0, chr_count_reg};
            cbm_pkg::CFG_CHR_RAM:   prdata = {31'd0, chr_ram_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.prg_bank_count = prg_count_reg;
    assign cfg.chr_bank_count = chr_count_reg;
    assign cfg.chr_is_ram     = chr_ram_reg;

    cbm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    cbm_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule
